### rtl/uartrx_pkg.sv
// Shared types and constants for the UART receive-FIFO register block.
// No dependencies; imported by every module of the block but uartrx_ram.
package uartrx_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RECV  = 2'd2
    } t_opcode;

    // register offsets relative to the bus base register
    localparam logic [2:0] OFS_DATA    = 3'd0;
    localparam logic [2:0] OFS_INT     = 3'd1;
    localparam logic [2:0] OFS_LSR     = 3'd5;
    localparam logic [2:0] OFS_SCRATCH = 3'd7;

    localparam int unsigned IER_RX_ENABLE_BIT = 0;
    localparam logic [7:0]  IIR_RX_DATA       = 8'h04;
    localparam logic [7:0]  LSR_DATA_READY    = 8'h01;

    // result of one item as it leaves the decode stage
    typedef struct packed {
        logic       pop;        // read_data comes from the FIFO memory
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       overrun;
    } t_result;

endpackage

### rtl/uartrx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module uartrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/uartrx_ctrl.sv
// Address decode, register file and FIFO pointers of the UART block.
// Depends on uartrx_pkg; drives the FIFO memory ports.
module uartrx_ctrl
    import uartrx_pkg::*;
#(
    parameter int RX_FIFO_DEPTH = 16,
    localparam int PTR_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1,
    localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_accept,
    input  logic [1:0]       i_opcode,
    input  logic [15:0]      i_bus_address,
    input  logic [7:0]       i_write_data,
    input  logic [7:0]       i_received_byte,
    output t_result          o_result,
    output logic             o_mem_we,
    output logic [PTR_W-1:0] o_mem_waddr,
    output logic [7:0]       o_mem_wdata,
    output logic             o_mem_re,
    output logic [PTR_W-1:0] o_mem_raddr
);

    logic [15:0]      r_base;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [7:0]       r_int_enable, n_int_enable;
    logic [7:0]       r_int_ident, n_int_ident;
    logic [7:0]       r_scratch, n_scratch;
    logic             r_irq, n_irq;

    logic [15:0] offset;
    logic        in_range;
    logic        fifo_full;
    logic        fifo_empty;
    t_result     res;
    logic        push;

    assign offset     = i_bus_address - r_base;
    assign in_range   = (offset[15:3] == 13'd0);
    assign fifo_full  = (r_count == CNT_W'(RX_FIFO_DEPTH));
    assign fifo_empty = (r_count == '0);

    always_comb begin
        n_count      = r_count;
        n_head       = r_head;
        n_tail       = r_tail;
        n_int_enable = r_int_enable;
        n_int_ident  = r_int_ident;
        n_scratch    = r_scratch;
        n_irq        = r_irq;
        push         = 1'b0;
        res          = '0;
        if (i_accept) begin
            case (t_opcode'(i_opcode))
                OP_READ: begin
                    if (in_range) begin
                        case (offset[2:0])
                            OFS_DATA: begin
                                n_irq = 1'b0;
                                if (!fifo_empty) begin
                                    res.pop = 1'b1;
                                    n_head  = (r_head == PTR_W'(RX_FIFO_DEPTH - 1)) ?
                                              '0 : r_head + 1'b1;
                                    n_count = r_count - 1'b1;
                                end
                            end
                            OFS_INT:     res.read_data = r_int_ident;
                            OFS_LSR:     res.read_data = fifo_empty ? 8'd0 : LSR_DATA_READY;
                            OFS_SCRATCH: res.read_data = r_scratch;
                            default:     res.read_data = 8'd0;
                        endcase
                    end
                end
                OP_WRITE: begin
                    if (in_range) begin
                        case (offset[2:0])
                            OFS_DATA: begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = i_write_data;
                            end
                            OFS_INT: begin
                                n_int_enable = i_write_data;
                                if (!i_write_data[IER_RX_ENABLE_BIT]) begin
                                    n_irq = 1'b0;
                                end
                            end
                            OFS_SCRATCH: n_scratch = i_write_data;
                            default: ;
                        endcase
                    end
                end
                OP_RECV: begin
                    if (fifo_full) begin
                        res.overrun = 1'b1;     // drop the byte
                    end else begin
                        push    = 1'b1;
                        n_tail  = (r_tail == PTR_W'(RX_FIFO_DEPTH - 1)) ?
                                  '0 : r_tail + 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_int_enable[IER_RX_ENABLE_BIT]) begin
                            n_int_ident = IIR_RX_DATA;
                            n_irq       = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        res.irq = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_count      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_int_enable <= '0;
            r_int_ident  <= '0;
            r_scratch    <= '0;
            r_irq        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            r_count      <= n_count;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_int_enable <= n_int_enable;
            r_int_ident  <= n_int_ident;
            r_scratch    <= n_scratch;
            r_irq        <= n_irq;
        end
    end

    // read at head on every item; the data is used only when the item pops
    assign o_result    = res;
    assign o_mem_we    = push;
    assign o_mem_waddr = r_tail;
    assign o_mem_wdata = i_received_byte;
    assign o_mem_re    = i_accept;
    assign o_mem_raddr = r_head;

endmodule

### rtl/uartrx_out.sv
// Two-entry result path: memory-read stage followed by the output register.
// Depends on uartrx_pkg for the result struct.
module uartrx_out
    import uartrx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_result    i_result,
    input  logic [7:0] i_mem_data,
    output logic       o_ready,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_irq_pending,
    output logic       o_rx_overrun
);

    logic    r_s1_valid;
    t_result r_s1;
    logic    r_s2_valid;
    t_result r_s2;
    t_result n_s2;
    logic    s2_free;
    logic    s1_move;

    assign s2_free = !r_s2_valid || !i_out_stall;
    assign s1_move = r_s1_valid && s2_free;
    assign o_ready = !r_s1_valid || s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_free) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // merge the popped byte into the result as it leaves s1
    always_comb begin
        n_s2           = r_s1;
        n_s2.pop       = 1'b0;
        n_s2.read_data = r_s1.pop ? i_mem_data : r_s1.read_data;
    end

    // memory data holds while s1 waits, since the read fires only on accept
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_result;
        end
        if (s1_move) begin
            r_s2 <= n_s2;
        end
    end

    assign o_out_valid   = r_s2_valid;
    assign o_read_data   = r_s2.read_data;
    assign o_tx_valid    = r_s2.tx_valid;
    assign o_tx_byte     = r_s2.tx_byte;
    assign o_irq_pending = r_s2.irq;
    assign o_rx_overrun  = r_s2.overrun;

endmodule

### rtl/uart_rx_fifo_register_model.sv
// Top level of the 16550-style UART register block with receive FIFO.
// Depends on uartrx_pkg, uartrx_ctrl, uartrx_ram and uartrx_out.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-----------------------------
//   input    | in        | i_in_valid / o_in_stall    | opcode, bus_address, data
//   output   | out       | o_out_valid / i_out_stall  | read_data, tx, irq, overrun
//   config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (bus base)
//
// One item per cycle sustained while the output is not stalled; the FIFO memory read
// and the decoded fields are registered at the edge that accepts an item, then move to
// the output register, from which the result drives the outputs.
// Two results can be held, so an item is still taken while a result waits; the input
// stalls only when both are held and the output is stalled, or while reset is asserted.
// Synchronous active-low reset clears pointers, registers and valids, holds input stall
// on and config ready off; the FIFO memory is not cleared and needs no clearing pass.
module uart_rx_fifo_register_model
    import uartrx_pkg::*;
#(
    parameter int RX_FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_received_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_irq_pending,
    output logic        o_rx_overrun
);

    localparam int PTR_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;

    logic             ready;
    logic             accept;
    t_result          result;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;

    // hold off both channels while reset is asserted
    assign o_cfg_ready = i_rst_n;
    assign o_in_stall  = !ready || !i_rst_n;
    assign accept      = i_in_valid && !o_in_stall;

    uartrx_ctrl #(
        .RX_FIFO_DEPTH(RX_FIFO_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_opcode       (i_opcode),
        .i_bus_address  (i_bus_address),
        .i_write_data   (i_write_data),
        .i_received_byte(i_received_byte),
        .o_result       (result),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr)
    );

    uartrx_ram #(
        .WIDTH(8),
        .DEPTH(RX_FIFO_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    uartrx_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_result     (result),
        .i_mem_data   (mem_rdata),
        .o_ready      (ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_irq_pending(o_irq_pending),
        .o_rx_overrun (o_rx_overrun)
    );

endmodule

### sim/tb_uart_rx_fifo_register_model.sv
`timescale 1ns / 100ps
// Self-checking testbench for uart_rx_fifo_register_model: queued bus reads, bus writes
// and line bytes are driven in bursts, and each result is checked against a local model.
// Depends on uartrx_pkg and the RTL of the block.
module tb_uart_rx_fifo_register_model
    import uartrx_pkg::*;
();

    localparam int FIFO_DEPTH  = 16;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 285;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_PRINTED = 100;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] OFS_FCR   = 3'd2;
    localparam logic [2:0] OFS_LCR   = 3'd3;
    localparam logic [2:0] OFS_MCR   = 3'd4;
    localparam logic [2:0] OFS_MSR   = 3'd6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  rbyte;
    } t_bus_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       overrun;
    } t_uart_result;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic [15:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic [1:0]  opcode        = '0;
    logic [15:0] bus_address   = '0;
    logic [7:0]  write_data    = '0;
    logic [7:0]  received_byte = '0;
    logic        out_stall     = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_read_data;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_irq_pending;
    logic        o_rx_overrun;

    // model of the register block
    logic [7:0]  rx_mem [FIFO_DEPTH];
    logic [4:0]  rx_level = '0;
    logic [3:0]  rd_ptr   = '0;
    logic [3:0]  wr_ptr   = '0;
    logic [7:0]  ier      = '0;
    logic [7:0]  iir      = '0;
    logic [7:0]  scr      = '0;
    logic        irq_q    = 1'b0;
    logic [15:0] base     = '0;

    t_bus_item    pending_items[$];
    t_uart_result expected_results[$];
    logic [15:0]  cur_base    = '0;
    logic         in_taken    = 1'b0;
    int           burst_left  = 1;
    int           gap_left    = 0;
    int           stall_mode  = 0;
    int           stall_hold  = 0;
    int           stall_phase = 0;
    int           idle_cycles = 0;
    int           mismatches  = 0;

    uart_rx_fifo_register_model dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (opcode),
        .i_bus_address   (bus_address),
        .i_write_data    (write_data),
        .i_received_byte (received_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_read_data     (o_read_data),
        .o_tx_valid      (o_tx_valid),
        .o_tx_byte       (o_tx_byte),
        .o_irq_pending   (o_irq_pending),
        .o_rx_overrun    (o_rx_overrun)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_uart_result predict_step(t_bus_item it);
        t_uart_result r;
        logic [15:0]  ofs;
        r   = '0;
        ofs = it.addr - base;
        case (it.opcode)
            OP_READ: begin
                if (ofs[15:3] == '0) begin
                    case (ofs[2:0])
                        OFS_DATA: begin
                            irq_q = 1'b0;
                            if (rx_level != '0) begin
                                r.read_data = rx_mem[rd_ptr];
                                rd_ptr      = rd_ptr + 1'b1;
                                rx_level    = rx_level - 1'b1;
                            end
                        end
                        OFS_INT:     r.read_data = iir;
                        OFS_LSR:     r.read_data = (rx_level != '0) ? LSR_DATA_READY : 8'h00;
                        OFS_SCRATCH: r.read_data = scr;
                        default:     r.read_data = 8'h00;
                    endcase
                end
            end
            OP_WRITE: begin
                if (ofs[15:3] == '0) begin
                    case (ofs[2:0])
                        OFS_DATA: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = it.wdata;
                        end
                        OFS_INT: begin
                            ier = it.wdata;
                            if (!ier[IER_RX_ENABLE_BIT]) irq_q = 1'b0;
                        end
                        OFS_SCRATCH: scr = it.wdata;
                        default: ;
                    endcase
                end
            end
            OP_RECV: begin
                if (rx_level == FIFO_DEPTH) begin
                    r.overrun = 1'b1;
                end else begin
                    rx_mem[wr_ptr] = it.rbyte;
                    wr_ptr         = wr_ptr + 1'b1;
                    rx_level       = rx_level + 1'b1;
                    if (ier[IER_RX_ENABLE_BIT]) begin
                        iir   = IIR_RX_DATA;
                        irq_q = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.irq = irq_q;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
    endtask

    // driver: hold a stalled item, otherwise advance through bursts and gaps
    always @(negedge clk) begin
        t_bus_item nxt;
        logic      present;
        nxt     = '0;
        present = 1'b0;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_items.size() != 0) begin
                nxt     = pending_items.pop_front();
                present = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
            in_valid <= present;
            if (present) begin
                opcode        <= nxt.opcode;
                bus_address   <= nxt.addr;
                write_data    <= nxt.wdata;
                received_byte <= nxt.rbyte;
            end
        end
    end

    // receiver stall pattern, switching mode now and then
    always @(negedge clk) begin
        if (stall_hold == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_hold = $urandom_range(20, 150);
        end else begin
            stall_hold--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_phase % 8) < 5);
        endcase
        stall_phase++;
    end

    // check results, predict accepted items, watch for a hang
    always @(posedge clk) begin
        t_uart_result got;
        t_uart_result want;
        logic         moved;
        if (!rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            in_taken <= in_valid && !o_in_stall;
            if (o_out_valid && !out_stall) begin
                moved = 1'b1;
                got   = '{o_read_data, o_tx_valid, o_tx_byte, o_irq_pending, o_rx_overrun};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", got.read_data, want.read_data);
                    check_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
                    check_field("tx_byte", got.tx_byte, want.tx_byte);
                    check_field("irq_pending", 8'(got.irq), 8'(want.irq));
                    check_field("rx_overrun", 8'(got.overrun), 8'(want.overrun));
                end
            end
            if (in_valid && !o_in_stall) begin
                moved = 1'b1;
                expected_results.push_back(
                    predict_step('{opcode, bus_address, write_data, received_byte}));
            end
            if (cfg_valid && o_cfg_ready) moved = 1'b1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_item(logic [1:0] op, int ofs, logic [7:0] wd, logic [7:0] rb);
        t_bus_item it;
        it = '{op, cur_base + 16'(ofs), wd, rb};
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!o_cfg_ready);
        base     = value;
        cur_base = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_sequence(output int n);
        int         kind;
        int         pick;
        logic [1:0] op;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(1, 20);
        for (int k = 0; k < n; k++) begin
            case (kind)
                0, 1, 2: add_item(OP_RECV, $urandom_range(0, 65535),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                3, 4: add_item(OP_READ, (k % 4 == 3) ? OFS_LSR : OFS_DATA,
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                5, 6: begin
                    op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
                    add_item(op, $urandom_range(0, 7), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                end
                7: add_item(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                8: begin
                    op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
                    add_item(op, $urandom_range(8, 65535), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                end
                default: begin
                    pick = $urandom_range(0, 4);
                    case (pick)
                        0:       add_item(OP_RECV, OFS_DATA, 8'h00,
                                          8'($urandom_range(0, 255)));
                        1:       add_item(OP_READ, OFS_DATA, 8'h00, 8'h00);
                        2:       add_item(OP_READ, OFS_INT, 8'h00, 8'h00);
                        3:       add_item(OP_READ, OFS_LSR, 8'h00, 8'h00);
                        default: add_item(OP_WRITE, OFS_INT, 8'($urandom_range(0, 255)),
                                          8'h00);
                    endcase
                end
            endcase
        end
    endtask

    // open with an unbroken run of line bytes so the FIFO overflows at least once
    task automatic fill_random(int count);
        int added;
        int n;
        for (int k = 0; k <= FIFO_DEPTH; k++)
            add_item(OP_RECV, $urandom_range(0, 65535), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        added = FIFO_DEPTH + 1;
        while (added < count) begin
            add_sequence(n);
            added += n;
        end
    endtask

    task automatic add_directed();
        add_item(OP_READ,   OFS_DATA,    8'h00, 8'h00);   // empty FIFO reads zero
        add_item(OP_READ,   OFS_LSR,     8'h00, 8'h00);
        add_item(OP_WRITE,  OFS_INT,     8'hFF, 8'h00);
        add_item(OP_RECV,   OFS_DATA,    8'h00, 8'h00);
        add_item(OP_READ,   OFS_INT,     8'h00, 8'h00);
        add_item(OP_READ,   OFS_LSR,     8'h00, 8'h00);
        add_item(OP_READ,   OFS_DATA,    8'h00, 8'h00);
        add_item(OP_WRITE,  OFS_SCRATCH, 8'hFF, 8'h00);
        add_item(OP_READ,   OFS_SCRATCH, 8'h00, 8'h00);
        add_item(OP_WRITE,  OFS_SCRATCH, 8'h00, 8'hFF);
        add_item(OP_WRITE,  OFS_DATA,    8'hFF, 8'h00);
        add_item(OP_WRITE,  OFS_DATA,    8'h00, 8'hFF);
        add_item(OP_READ,   OFS_FCR,     8'h00, 8'h00);
        add_item(OP_READ,   OFS_LCR,     8'h00, 8'h00);
        add_item(OP_READ,   OFS_MCR,     8'h00, 8'h00);
        add_item(OP_READ,   OFS_MSR,     8'h00, 8'h00);
        add_item(OP_WRITE,  OFS_LCR,     8'hFF, 8'hFF);
        add_item(OP_UNUSED, OFS_DATA,    8'hFF, 8'hFF);
        add_item(OP_READ,   8,           8'h00, 8'h00);   // just past the register window
        add_item(OP_WRITE,  -1,          8'hFF, 8'h00);   // just below base, wraps
        add_item(OP_RECV,   OFS_DATA,    8'h00, 8'hFF);
        add_item(OP_WRITE,  OFS_INT,     8'hFE, 8'h00);   // enable bit clear drops irq
        add_item(OP_READ,   OFS_DATA,    8'h00, 8'h00);
        add_item(OP_READ,   OFS_SCRATCH, 8'h00, 8'h00);
    endtask

    initial begin
        logic [15:0] phase_base [PHASES];
        phase_base[0] = 16'h0000;
        phase_base[1] = 16'hFFFF;
        phase_base[2] = 16'hFFFC;
        phase_base[3] = 16'($urandom_range(0, 65535));
        phase_base[4] = 16'h8000;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_base(phase_base[p]);
            if (p == 0) add_directed();
            fill_random(PHASE_ITEMS / 2);
            // hold the sender until every outstanding result is back
            wait_drained();
            fill_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        end
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
